// File: hdl/ppd_pkg.sv
// ============================================================================
// ppd_pkg: shared types and constants for the point polar and distance block
// Holds the stage payload structs, datapath widths and the arctangent table.
// ============================================================================
`default_nettype none

package ppd_pkg;

    localparam int COORD_W     = 16;
    localparam int MAG_W       = 16;
    localparam int SQ_W        = 32;
    localparam int RAD_W       = 34;
    localparam int REM_W       = 21;
    localparam int ROOT_W      = 17;
    localparam int DP_W        = 64;
    localparam int Z_W         = 34;
    localparam int CORDIC_ITER = 32;
    localparam int SQRT_STEPS  = 17;
    localparam int NORM_TOP    = 58;
    localparam int ANGLE_W     = 17;
    localparam int RADIUS_W    = 16;
    localparam int DIST_W      = 17;

    typedef struct packed {
        logic [SQ_W-1:0]  sq_px;
        logic [SQ_W-1:0]  sq_py;
        logic [SQ_W-1:0]  sq_dx;
        logic [SQ_W-1:0]  sq_dy;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic             x_neg;
        logic             y_neg;
        logic             same;
    } ppd_front_t;

    typedef struct packed {
        logic [RAD_W-1:0]  src;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } ppd_sqrt_t;

    typedef struct packed {
        logic signed [DP_W-1:0] cx;
        logic signed [DP_W-1:0] cy;
        logic signed [Z_W-1:0]  z;
        ppd_sqrt_t              rad;
        ppd_sqrt_t              dst;
        logic                   x_neg;
        logic                   y_neg;
        logic                   origin;
        logic                   same;
    } ppd_cell_t;

    // atan(2^-i) in units of 2*pi / 2^32, rounded to nearest.
    function automatic logic signed [Z_W-1:0] arc_angle(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 34'sd536870912;
            1:       v = 34'sd316933406;
            2:       v = 34'sd167458907;
            3:       v = 34'sd85004756;
            4:       v = 34'sd42667331;
            5:       v = 34'sd21354465;
            6:       v = 34'sd10679838;
            7:       v = 34'sd5340245;
            8:       v = 34'sd2670163;
            9:       v = 34'sd1335087;
            10:      v = 34'sd667544;
            11:      v = 34'sd333772;
            12:      v = 34'sd166886;
            13:      v = 34'sd83443;
            14:      v = 34'sd41722;
            15:      v = 34'sd20861;
            16:      v = 34'sd10430;
            17:      v = 34'sd5215;
            18:      v = 34'sd2608;
            19:      v = 34'sd1304;
            20:      v = 34'sd652;
            21:      v = 34'sd326;
            22:      v = 34'sd163;
            23:      v = 34'sd81;
            24:      v = 34'sd41;
            25:      v = 34'sd20;
            26:      v = 34'sd10;
            27:      v = 34'sd5;
            28:      v = 34'sd3;
            29:      v = 34'sd1;
            30:      v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ppd_if.sv
// ============================================================================
// ppd_in_if / ppd_out_if: valid-ready channels of the polar and distance block
// One word moves when valid and ready are both high at a rising clock edge.
// ============================================================================
`default_nettype none

interface ppd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] ref_x;
    logic signed [15:0] ref_y;

    modport source (output valid, point_x, point_y, ref_x, ref_y, input ready);
    modport sink   (input valid, point_x, point_y, ref_x, ref_y, output ready);
endinterface

interface ppd_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] radius;
    logic signed [16:0] angle;
    logic        [16:0] ref_distance;
    logic               same_point;

    modport source (output valid, radius, angle, ref_distance, same_point, input ready);
    modport sink   (input valid, radius, angle, ref_distance, same_point, output ready);
endinterface

`default_nettype wire

// File: hdl/ppd_front.sv
// ============================================================================
// ppd_front: magnitudes and squares
// Takes absolute values of the point and of the point-to-reference offset and
// registers their squares.
// ============================================================================
`default_nettype none

module ppd_front (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] point_y,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] ref_x,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] ref_y,
    output ppd_pkg::ppd_front_t                    q
);
    import ppd_pkg::*;

    ppd_front_t            q_reg;
    ppd_front_t            q_next;
    logic signed [COORD_W:0] diff_x;
    logic signed [COORD_W:0] diff_y;
    logic [COORD_W:0]      abs_px;
    logic [COORD_W:0]      abs_py;
    logic [COORD_W:0]      abs_dx;
    logic [COORD_W:0]      abs_dy;

    always_comb
    begin
        diff_x = {point_x[COORD_W-1], point_x} - {ref_x[COORD_W-1], ref_x};
        diff_y = {point_y[COORD_W-1], point_y} - {ref_y[COORD_W-1], ref_y};
        abs_px = point_x[COORD_W-1] ? -{1'b1, point_x} : {1'b0, point_x};
        abs_py = point_y[COORD_W-1] ? -{1'b1, point_y} : {1'b0, point_y};
        abs_dx = diff_x[COORD_W] ? -diff_x : diff_x;
        abs_dy = diff_y[COORD_W] ? -diff_y : diff_y;
        q_next.ax    = abs_px[MAG_W-1:0];
        q_next.ay    = abs_py[MAG_W-1:0];
        q_next.sq_px = abs_px[MAG_W-1:0] * abs_px[MAG_W-1:0];
        q_next.sq_py = abs_py[MAG_W-1:0] * abs_py[MAG_W-1:0];
        q_next.sq_dx = abs_dx[MAG_W-1:0] * abs_dx[MAG_W-1:0];
        q_next.sq_dy = abs_dy[MAG_W-1:0] * abs_dy[MAG_W-1:0];
        q_next.x_neg = point_x[COORD_W-1];
        q_next.y_neg = point_y[COORD_W-1];
        q_next.same  = (point_x == ref_x) && (point_y == ref_y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: hdl/ppd_norm.sv
// ============================================================================
// ppd_norm: radicands and vector normalization
// Sums the squares and shifts the magnitudes so the larger one sits just
// below the top of the rotation datapath.
// ============================================================================
`default_nettype none

module ppd_norm (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire ppd_pkg::ppd_front_t d,
    output ppd_pkg::ppd_cell_t       q
);
    import ppd_pkg::*;

    ppd_cell_t        q_reg;
    ppd_cell_t        q_next;
    logic [MAG_W-1:0] big;
    logic [3:0]       msb;
    logic [5:0]       shamt;

    always_comb
    begin
        big = (d.ax > d.ay) ? d.ax : d.ay;
        msb = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (big[i])
            begin
                msb = 4'(i);
            end
        end
        shamt = 6'(NORM_TOP) - {2'b00, msb};

        q_next.cx       = $signed({{(DP_W-MAG_W){1'b0}}, d.ax} << shamt);
        q_next.cy       = $signed({{(DP_W-MAG_W){1'b0}}, d.ay} << shamt);
        q_next.z        = '0;
        q_next.rad.src  = {1'b0, {1'b0, d.sq_px} + {1'b0, d.sq_py}};
        q_next.rad.rem  = '0;
        q_next.rad.root = '0;
        q_next.dst.src  = {1'b0, {1'b0, d.sq_dx} + {1'b0, d.sq_dy}};
        q_next.dst.rem  = '0;
        q_next.dst.root = '0;
        q_next.x_neg    = d.x_neg;
        q_next.y_neg    = d.y_neg;
        q_next.origin   = (d.ax == '0) && (d.ay == '0);
        q_next.same     = d.same;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: hdl/ppd_cell.sv
// ============================================================================
// ppd_cell: one cell of the rotation and square-root chain
// Does one vectoring rotation and, in the first cells, one root digit for
// each of the two distances.
// ============================================================================
`default_nettype none

module ppd_cell #(
    parameter int IDX = 0
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire ppd_pkg::ppd_cell_t d,
    output ppd_pkg::ppd_cell_t      q
);
    import ppd_pkg::*;

    ppd_cell_t              q_reg;
    ppd_cell_t              q_next;
    logic signed [DP_W-1:0] dx;
    logic signed [DP_W-1:0] dy;

    function automatic ppd_sqrt_t root_digit(input ppd_sqrt_t s);
        ppd_sqrt_t        r;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh = {s.rem[REM_W-3:0], s.src[RAD_W-1:RAD_W-2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
        r.src  = {s.src[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        q_next = d;
        dx = d.cx >>> IDX;
        dy = d.cy >>> IDX;
        if (!d.cy[DP_W-1])
        begin
            q_next.cx = d.cx + dy;
            q_next.cy = d.cy - dx;
            q_next.z  = d.z + arc_angle(IDX);
        end
        else
        begin
            q_next.cx = d.cx - dy;
            q_next.cy = d.cy + dx;
            q_next.z  = d.z - arc_angle(IDX);
        end
        if (IDX < SQRT_STEPS)
        begin
            q_next.rad = root_digit(d.rad);
            q_next.dst = root_digit(d.dst);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: hdl/ppd_back.sv
// ============================================================================
// ppd_back: angle finish and output register
// Clamps the first-quadrant angle, mirrors it into the point's quadrant and
// rounds it to the output step.
// ============================================================================
`default_nettype none

module ppd_back (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire ppd_pkg::ppd_cell_t              d,
    output logic        [ppd_pkg::RADIUS_W-1:0]  radius,
    output logic signed [ppd_pkg::ANGLE_W-1:0]   angle,
    output logic        [ppd_pkg::DIST_W-1:0]    ref_distance,
    output logic                                 same_point
);
    import ppd_pkg::*;

    localparam logic signed [Z_W-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [Z_W-1:0] HALF    = 34'sd2147483648;
    localparam logic signed [Z_W-1:0] ROUND   = 34'sd32768;

    logic        [RADIUS_W-1:0] radius_reg;
    logic        [RADIUS_W-1:0] radius_next;
    logic signed [ANGLE_W-1:0]  angle_reg;
    logic signed [ANGLE_W-1:0]  angle_next;
    logic        [DIST_W-1:0]   dist_reg;
    logic        [DIST_W-1:0]   dist_next;
    logic                       same_reg;
    logic                       same_next;
    logic signed [Z_W-1:0]      zc;
    logic signed [Z_W-1:0]      full;
    logic signed [Z_W-1:0]      rounded;

    always_comb
    begin
        if (d.z < 0)
        begin
            zc = '0;
        end
        else if (d.z > QUARTER)
        begin
            zc = QUARTER;
        end
        else
        begin
            zc = d.z;
        end
        if (!d.x_neg)
        begin
            full = d.y_neg ? -zc : zc;
        end
        else
        begin
            full = d.y_neg ? (zc - HALF) : (HALF - zc);
        end
        rounded     = full + ROUND;
        angle_next  = d.origin ? '0 : rounded[32:16];
        radius_next = d.rad.root[RADIUS_W-1:0];
        dist_next   = d.dst.root;
        same_next   = d.same;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            radius_reg <= radius_next;
            angle_reg  <= angle_next;
            dist_reg   <= dist_next;
            same_reg   <= same_next;
        end
    end

    assign radius       = radius_reg;
    assign angle        = angle_reg;
    assign ref_distance = dist_reg;
    assign same_point   = same_reg;

endmodule

`default_nettype wire

// File: hdl/point_polar_and_distance.sv
// ============================================================================
// point_polar_and_distance: radius, angle and reference distance of a point
// Pipelined vectoring rotation chain with two digit-by-digit square roots.
// ============================================================================
// The chain of 32 rotation cells, one register stage each, makes up most of the
//   pipeline from an accepted input word to its result word.
// Throughput: one word per cycle unless the output stalls. Every stage has its
//   own valid bit, so empty stages fill while a result waits in the output register.
// Reset (rst_n, asynchronous, active low) clears all valid bits; the data
//   registers keep no reset value.
`default_nettype none

module point_polar_and_distance (
    input wire logic clk,
    input wire logic rst_n,
    ppd_in_if.sink   in_ch,
    ppd_out_if.source out_ch
);
    import ppd_pkg::*;

    // Stage 0 squares, stage 1 normalizes, stages 2..33 are rotation cells
    // (the first 17 also develop one root digit each), stage 34 is output.
    localparam int N_STAGE = CORDIC_ITER + 3;

    logic [N_STAGE-1:0] valid_reg;
    logic [N_STAGE-1:0] valid_next;
    logic [N_STAGE:0]   en;

    ppd_front_t front_q;
    ppd_cell_t  chain [CORDIC_ITER+1];

    // A stage may load when it is empty or when its own word moves on.
    assign en[N_STAGE] = out_ch.ready;
    genvar k;
    generate
        for (k = 0; k < N_STAGE; k++)
        begin : g_en
            assign en[k] = !valid_reg[k] || en[k+1];
        end
    endgenerate

    always_comb
    begin
        valid_next = valid_reg;
        for (int s = 0; s < N_STAGE; s++)
        begin
            if (en[s])
            begin
                valid_next[s] = (s == 0) ? in_ch.valid : valid_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ch.ready  = en[0];
    assign out_ch.valid = valid_reg[N_STAGE-1];

    ppd_front u_front (
        .clk     (clk),
        .en      (en[0]),
        .point_x (in_ch.point_x),
        .point_y (in_ch.point_y),
        .ref_x   (in_ch.ref_x),
        .ref_y   (in_ch.ref_y),
        .q       (front_q)
    );

    ppd_norm u_norm (
        .clk (clk),
        .en  (en[1]),
        .d   (front_q),
        .q   (chain[0])
    );

    generate
        for (k = 0; k < CORDIC_ITER; k++)
        begin : g_cell
            ppd_cell #(.IDX(k)) u_cell (
                .clk (clk),
                .en  (en[k+2]),
                .d   (chain[k]),
                .q   (chain[k+1])
            );
        end
    endgenerate

    ppd_back u_back (
        .clk          (clk),
        .en           (en[N_STAGE-1]),
        .d            (chain[CORDIC_ITER]),
        .radius       (out_ch.radius),
        .angle        (out_ch.angle),
        .ref_distance (out_ch.ref_distance),
        .same_point   (out_ch.same_point)
    );

`ifndef SYNTH
    // Equal points are at distance zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.same_point |-> out_ch.ref_distance == '0)
        else $error("same_point set with nonzero ref_distance");

    // Only the origin has zero radius, and its angle is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.radius == '0 |-> out_ch.angle == '0)
        else $error("zero radius with nonzero angle");

    // The angle never leaves the half-turn range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.angle >= -17'sd32768 && out_ch.angle <= 17'sd32768)
        else $error("angle out of range");

    // An accepted word always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> valid_reg[0])
        else $error("accepted word lost at the first stage");

    // A stalled result stays at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.angle))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// File: test/tb_point_polar_and_distance.sv
// ============================================================================
// tb_point_polar_and_distance: self-checking bench for the polar/distance block
// Drives coordinate words in bursts, stalls the output, and compares every
// result word field by field with a behavioral prediction of radius, angle,
// reference distance and the equality flag.
// ============================================================================
`timescale 1ns / 1ps

module tb_point_polar_and_distance;
    import ppd_pkg::*;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
    } coord_word_t;

    typedef struct packed {
        logic        [15:0] radius;
        logic signed [16:0] angle;
        logic        [16:0] ref_dist;
        logic               same;
    } polar_word_t;

    logic clk;
    logic rst_n;

    ppd_in_if  in_ch ();
    ppd_out_if out_ch ();

    point_polar_and_distance dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    coord_word_t pending_q[$];
    polar_word_t expected_q[$];
    int          errors;
    int          cycle_count;
    bit          stim_done;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Floor of the square root of a*a + b*b, built bit by bit from the top.
    function automatic logic [34:0] hypot_root(input logic [33:0] a, input logic [33:0] b);
        logic [127:0] s;
        logic [127:0] c2;
        logic [34:0]  r;
        logic [34:0]  c;
        s = 128'(a) * 128'(a) + 128'(b) * 128'(b);
        r = '0;
        for (int bit_i = 34; bit_i >= 0; bit_i--)
        begin
            c = r | (35'd1 << bit_i);
            c2 = 128'(c) * 128'(c);
            if (c2 <= s)
                r = c;
        end
        return r;
    endfunction

    // Binary angle of (x, y): normalized vectoring rotation in 64-bit arithmetic,
    // quadrant fix-up, then rounding from 2^32 steps per turn down to 2^16.
    function automatic logic signed [63:0] point_angle(input logic signed [63:0] x,
                                                       input logic signed [63:0] y);
        logic [63:0]        ax;
        logic [63:0]        ay;
        logic [63:0]        big;
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] z;
        logic signed [63:0] a;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        if (ax == 0 && ay == 0)
            return 64'sd0;
        big = (ax > ay) ? ax : ay;
        while (big < (64'd1 << 58))
        begin
            big = big << 1;
            ax = ax << 1;
            ay = ay << 1;
        end
        cx = ax;
        cy = ay;
        z = 0;
        for (int i = 0; i < 32; i++)
        begin
            dx = cx >>> i;
            dy = cy >>> i;
            if (cy >= 0)
            begin
                cx = cx + dy;
                cy = cy - dx;
                z = z + 64'(arc_angle(i));
            end
            else
            begin
                cx = cx - dy;
                cy = cy + dx;
                z = z - 64'(arc_angle(i));
            end
        end
        if (z < 0)
            z = 0;
        if (z > (64'sd1 <<< 30))
            z = 64'sd1 <<< 30;
        if (x >= 0)
            a = (y >= 0) ? z : -z;
        else
            a = (y >= 0) ? (64'sd1 <<< 31) - z : z - (64'sd1 <<< 31);
        return (a + (64'sd1 <<< 15)) >>> 16;
    endfunction

    function automatic polar_word_t predict_polar(input coord_word_t w);
        polar_word_t        p;
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] ang;
        logic [34:0]        r;
        px = w.px;
        py = w.py;
        dx = px - 64'(w.rx);
        dy = py - 64'(w.ry);
        r = hypot_root(34'((px < 0) ? -px : px), 34'((py < 0) ? -py : py));
        p.radius = r[15:0];
        ang = point_angle(px, py);
        p.angle = ang[16:0];
        r = hypot_root(34'((dx < 0) ? -dx : dx), 34'((dy < 0) ? -dy : dy));
        p.ref_dist = r[16:0];
        p.same = (w.px == w.rx) && (w.py == w.ry);
        return p;
    endfunction

    // Pick a coordinate: extremes and axis values often, full random otherwise.
    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_word(input logic signed [15:0] px, input logic signed [15:0] py,
                             input logic signed [15:0] rx, input logic signed [15:0] ry);
        coord_word_t w;
        w.px = px;
        w.py = py;
        w.rx = rx;
        w.ry = ry;
        pending_q.push_back(w);
    endtask

    // Stimulus: directed corners first, then random words.
    initial
    begin
        coord_word_t w;
        errors = 0;
        stim_done = 1'b0;
        // Origin, and the point equal to its reference.
        push_word(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        push_word(16'sd5, -16'sd7, 16'sd5, -16'sd7);
        // The four axes; the negative x axis gives plus a half turn.
        push_word(16'sd100, 16'sd0, 16'sd0, 16'sd0);
        push_word(-16'sd100, 16'sd0, 16'sd0, 16'sd0);
        push_word(16'sd0, 16'sd100, 16'sd0, 16'sd0);
        push_word(16'sd0, -16'sd100, 16'sd0, 16'sd0);
        // Extreme coordinates, among them the largest radius and the largest distance.
        push_word(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        push_word(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        push_word(16'sh8000, 16'sh0000, 16'sh7fff, 16'sh0000);
        push_word(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        push_word(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        push_word(16'sh8000, -16'sd1, 16'sd0, 16'sd0);
        push_word(16'sh8000, 16'sd1, 16'sd0, 16'sd0);
        // Diagonals in every quadrant and the smallest nonzero points.
        push_word(16'sd1, 16'sd1, -16'sd1, -16'sd1);
        push_word(-16'sd1, 16'sd1, 16'sd1, -16'sd1);
        push_word(-16'sd1, -16'sd1, 16'sd0, 16'sd1);
        push_word(16'sd1, -16'sd1, 16'sd1, 16'sd0);
        push_word(16'sd3, 16'sd4, 16'sd0, 16'sd0);
        push_word(-16'sd1, 16'sd0, -16'sd1, 16'sd1);
        push_word(16'shffff, 16'shaaaa, 16'sh5555, 16'shffff);
        for (int n = 0; n < 550; n++)
        begin
            w.px = pick_coord();
            w.py = pick_coord();
            if ($urandom_range(0, 7) == 0)
            begin
                w.rx = w.px;
                w.ry = w.py;
            end
            else
            begin
                w.rx = pick_coord();
                w.ry = pick_coord();
            end
            pending_q.push_back(w);
        end
        stim_done = 1'b1;
    end

    // Driver: bursts of random length separated by random gaps. A word stays
    // on the bus until it is taken, and valid is assigned once per edge.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.point_x <= '0;
            in_ch.point_y <= '0;
            in_ch.ref_x   <= '0;
            in_ch.ref_y   <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(predict_polar({in_ch.point_x, in_ch.point_y,
                                                    in_ch.ref_x, in_ch.ref_y}));
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                coord_word_t w;
                w = pending_q.pop_front();
                burst_left--;
                in_ch.valid   <= 1'b1;
                in_ch.point_x <= w.px;
                in_ch.point_y <= w.py;
                in_ch.ref_x   <= w.rx;
                in_ch.ref_y   <= w.ry;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver stall pattern, with one long hold-off early in the run so the
    // pipeline fills and backs up onto the input.
    int stall_count;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_count = 0;
        end
        else
        begin
            stall_count++;
            if (stall_count >= 200 && stall_count < 400)
                out_ch.ready <= 1'b0;
            else if (stall_count >= 1000 && stall_count < 1300)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result word with no prediction waiting", $realtime);
                errors++;
            end
            else
            begin
                polar_word_t e;
                e = expected_q.pop_front();
                if (out_ch.radius !== e.radius)
                begin
                    $display("%0t: radius expected %0d actual %0d", $realtime,
                             e.radius, out_ch.radius);
                    errors++;
                end
                if (out_ch.angle !== e.angle)
                begin
                    $display("%0t: angle expected %0d actual %0d", $realtime,
                             e.angle, out_ch.angle);
                    errors++;
                end
                if (out_ch.ref_distance !== e.ref_dist)
                begin
                    $display("%0t: ref_distance expected %0d actual %0d", $realtime,
                             e.ref_dist, out_ch.ref_distance);
                    errors++;
                end
                if (out_ch.same_point !== e.same)
                begin
                    $display("%0t: same_point expected %0b actual %0b", $realtime,
                             e.same, out_ch.same_point);
                    errors++;
                end
            end
        end
    end

    // Watchdog: fails the run once it goes far beyond the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 200000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        @(posedge clk);
        while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
            @(posedge clk);
        // Let any stray word past the pipeline depth show up.
        repeat (60) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: point_polar_and_distance.f
hdl/ppd_pkg.sv
hdl/ppd_if.sv
hdl/ppd_front.sv
hdl/ppd_norm.sv
hdl/ppd_cell.sv
hdl/ppd_back.sv
hdl/point_polar_and_distance.sv
test/tb_point_polar_and_distance.sv
